/* hw/rtl/pne2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pne2d_pkg
// Types, operation codes and constants shared by the 2D normal estimator.
// ----------------------------------------------------------------------------
package pne2d_pkg;

	typedef struct packed {
		logic signed [23:0] pt_x;
		logic signed [23:0] pt_y;
		logic signed [23:0] query_x;
		logic signed [23:0] query_y;
		logic               no_point;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic        [13:0] view_angle;
		logic        [1:0]  status;
	} result_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FEW  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_DROP = 2'd3;

	localparam logic REG_VIEW_X = 1'b0;
	localparam logic REG_VIEW_Y = 1'b1;

	localparam logic [13:0] HALF_PI_Q13  = 14'd12868;
	localparam int          CORDIC_STEPS = 21;
	localparam int          SQRT_STEPS   = 32;
	localparam int          DIV_STEPS    = 15;

	typedef logic [4:0] op_t;
	localparam op_t OP_NOP       = 5'd0;
	localparam op_t OP_LOAD      = 5'd1;
	localparam op_t OP_DIFF      = 5'd2;
	localparam op_t OP_ACC_X     = 5'd3;
	localparam op_t OP_ACC_Y     = 5'd4;
	localparam op_t OP_ACC_XY    = 5'd5;
	localparam op_t OP_COV_XX    = 5'd6;
	localparam op_t OP_COV_YY    = 5'd7;
	localparam op_t OP_COV_XY    = 5'd8;
	localparam op_t OP_DE        = 5'd9;
	localparam op_t OP_SHR       = 5'd10;
	localparam op_t OP_SQ0       = 5'd11;
	localparam op_t OP_SQ1       = 5'd12;
	localparam op_t OP_SQRT      = 5'd13;
	localparam op_t OP_AXIS      = 5'd14;
	localparam op_t OP_CANON     = 5'd15;
	localparam op_t OP_TWO       = 5'd16;
	localparam op_t OP_UMAG      = 5'd17;
	localparam op_t OP_UNORM     = 5'd18;
	localparam op_t OP_DIVX_INIT = 5'd19;
	localparam op_t OP_DIVY_INIT = 5'd20;
	localparam op_t OP_DIV_STEP  = 5'd21;
	localparam op_t OP_NX        = 5'd22;
	localparam op_t OP_NY        = 5'd23;
	localparam op_t OP_DOT0      = 5'd24;
	localparam op_t OP_DOT1      = 5'd25;
	localparam op_t OP_CRS0      = 5'd26;
	localparam op_t OP_CRS1      = 5'd27;
	localparam op_t OP_FLIP      = 5'd28;
	localparam op_t OP_ANORM     = 5'd29;
	localparam op_t OP_CINIT     = 5'd30;
	localparam op_t OP_CSTEP     = 5'd31;

	// The multiplier select field's spare codes are not used for result writes;
	// a separate code field selects the result kind.
	typedef logic [1:0] out_t;
	localparam out_t OUT_NONE  = 2'd0;
	localparam out_t OUT_FEW   = 2'd1;
	localparam out_t OUT_ZERO  = 2'd2;
	localparam out_t OUT_VALID = 2'd3;

	typedef logic [3:0] mul_t;
	localparam mul_t MS_NONE = 4'd0;
	localparam mul_t MS_DXDX = 4'd1;
	localparam mul_t MS_DYDY = 4'd2;
	localparam mul_t MS_DXDY = 4'd3;
	localparam mul_t MS_SXSX = 4'd4;
	localparam mul_t MS_SYSY = 4'd5;
	localparam mul_t MS_SXSY = 4'd6;
	localparam mul_t MS_AA   = 4'd7;
	localparam mul_t MS_BB   = 4'd8;
	localparam mul_t MS_VXNX = 4'd9;
	localparam mul_t MS_VYNY = 4'd10;
	localparam mul_t MS_VXNY = 4'd11;
	localparam mul_t MS_VYNX = 4'd12;

	typedef struct packed {
		op_t        op;
		mul_t       mul;
		out_t       res;
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic has_point;
		logic is_last;
		logic few;
		logic two;
		logic big28;
		logic unorm_ok;
		logic anorm_ok;
		logic vec_zero;
		logic ang_zero;
	} stat_t;

	// Arctangent of 2^-i in Q.20 radians.
	function automatic logic [20:0] atan_q20(input logic [4:0] i);
		logic [20:0] v;
		case (i)
			5'd0:    v = 21'd823550;
			5'd1:    v = 21'd486170;
			5'd2:    v = 21'd256879;
			5'd3:    v = 21'd130396;
			5'd4:    v = 21'd65451;
			5'd5:    v = 21'd32757;
			5'd6:    v = 21'd16383;
			5'd7:    v = 21'd8192;
			5'd8:    v = 21'd4096;
			5'd9:    v = 21'd2048;
			5'd10:   v = 21'd1024;
			5'd11:   v = 21'd512;
			5'd12:   v = 21'd256;
			5'd13:   v = 21'd128;
			5'd14:   v = 21'd64;
			5'd15:   v = 21'd32;
			5'd16:   v = 21'd16;
			5'd17:   v = 21'd8;
			5'd18:   v = 21'd4;
			5'd19:   v = 21'd2;
			5'd20:   v = 21'd1;
			default: v = 21'd0;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/pne2d_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pne2d_ctrl
// Sequencer that steps the datapath through accumulation and the per-group
// eigenvector, unit scaling, viewpoint and angle computation.
// ----------------------------------------------------------------------------
module pne2d_ctrl import pne2d_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	localparam logic [5:0] S_IDLE     = 6'd0;
	localparam logic [5:0] S_DIFF     = 6'd1;
	localparam logic [5:0] S_MXX      = 6'd2;
	localparam logic [5:0] S_AX       = 6'd3;
	localparam logic [5:0] S_AY       = 6'd4;
	localparam logic [5:0] S_AXY      = 6'd5;
	localparam logic [5:0] S_FIN      = 6'd6;
	localparam logic [5:0] S_C1       = 6'd7;
	localparam logic [5:0] S_C2       = 6'd8;
	localparam logic [5:0] S_C3       = 6'd9;
	localparam logic [5:0] S_C4       = 6'd10;
	localparam logic [5:0] S_DE       = 6'd11;
	localparam logic [5:0] S_SHR      = 6'd12;
	localparam logic [5:0] S_Q2       = 6'd13;
	localparam logic [5:0] S_Q3       = 6'd14;
	localparam logic [5:0] S_SQRT     = 6'd15;
	localparam logic [5:0] S_AXIS     = 6'd16;
	localparam logic [5:0] S_CANON    = 6'd17;
	localparam logic [5:0] S_ZCHK     = 6'd18;
	localparam logic [5:0] S_UNORM    = 6'd19;
	localparam logic [5:0] S_DIVX     = 6'd20;
	localparam logic [5:0] S_DIV      = 6'd21;
	localparam logic [5:0] S_NX       = 6'd22;
	localparam logic [5:0] S_DIVY     = 6'd23;
	localparam logic [5:0] S_NY       = 6'd24;
	localparam logic [5:0] S_D1       = 6'd25;
	localparam logic [5:0] S_D2       = 6'd26;
	localparam logic [5:0] S_D3       = 6'd27;
	localparam logic [5:0] S_D4       = 6'd28;
	localparam logic [5:0] S_D5       = 6'd29;
	localparam logic [5:0] S_FLIP     = 6'd30;
	localparam logic [5:0] S_ANORM    = 6'd31;
	localparam logic [5:0] S_CORD     = 6'd32;
	localparam logic [5:0] S_OUT_OK   = 6'd33;
	localparam logic [5:0] S_OUT_FEW  = 6'd34;
	localparam logic [5:0] S_OUT_ZERO = 6'd35;

	logic [5:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       pass_q, pass_d;
	logic       divy_q, divy_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		pass_d   = pass_q;
		divy_d   = divy_q;
		cmd.op   = OP_NOP;
		cmd.mul  = MS_NONE;
		cmd.res  = OUT_NONE;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.op = OP_DIFF;
				if (stat.has_point) state_d = S_MXX;
				else if (stat.is_last) state_d = S_FIN;
				else state_d = S_IDLE;
			end
			S_MXX: begin
				cmd.mul = MS_DXDX;
				state_d = S_AX;
			end
			S_AX: begin
				cmd.op  = OP_ACC_X;
				cmd.mul = MS_DYDY;
				state_d = S_AY;
			end
			S_AY: begin
				cmd.op  = OP_ACC_Y;
				cmd.mul = MS_DXDY;
				state_d = S_AXY;
			end
			S_AXY: begin
				cmd.op  = OP_ACC_XY;
				state_d = stat.is_last ? S_FIN : S_IDLE;
			end
			S_FIN: begin
				pass_d = 1'b0;
				if (stat.few) begin
					state_d = S_OUT_FEW;
				end else if (stat.two) begin
					cmd.op  = OP_TWO;
					state_d = S_ZCHK;
				end else begin
					state_d = S_C1;
				end
			end
			S_C1: begin
				cmd.mul = MS_SXSX;
				state_d = S_C2;
			end
			S_C2: begin
				cmd.op  = OP_COV_XX;
				cmd.mul = MS_SYSY;
				state_d = S_C3;
			end
			S_C3: begin
				cmd.op  = OP_COV_YY;
				cmd.mul = MS_SXSY;
				state_d = S_C4;
			end
			S_C4: begin
				cmd.op  = OP_COV_XY;
				state_d = S_DE;
			end
			S_DE: begin
				cmd.op  = OP_DE;
				state_d = S_SHR;
			end
			S_SHR: begin
				if (stat.big28) begin
					cmd.op = OP_SHR;
				end else begin
					cmd.mul = MS_AA;
					state_d = S_Q2;
				end
			end
			S_Q2: begin
				cmd.op  = OP_SQ0;
				cmd.mul = MS_BB;
				state_d = S_Q3;
			end
			S_Q3: begin
				cmd.op  = OP_SQ1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == 5'(SQRT_STEPS - 1)) state_d = pass_q ? S_DIVX : S_AXIS;
			end
			S_AXIS: begin
				cmd.op  = OP_AXIS;
				state_d = S_CANON;
			end
			S_CANON: begin
				cmd.op  = OP_CANON;
				state_d = S_ZCHK;
			end
			S_ZCHK: begin
				if (stat.vec_zero) begin
					state_d = S_OUT_ZERO;
				end else begin
					cmd.op  = OP_UMAG;
					pass_d  = 1'b1;
					state_d = S_UNORM;
				end
			end
			S_UNORM: begin
				if (stat.unorm_ok) begin
					cmd.mul = MS_AA;
					state_d = S_Q2;
				end else begin
					cmd.op = OP_UNORM;
				end
			end
			S_DIVX: begin
				cmd.op  = OP_DIVX_INIT;
				divy_d  = 1'b0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == 5'(DIV_STEPS - 1)) state_d = divy_q ? S_NY : S_NX;
			end
			S_NX: begin
				cmd.op  = OP_NX;
				state_d = S_DIVY;
			end
			S_DIVY: begin
				cmd.op  = OP_DIVY_INIT;
				divy_d  = 1'b1;
				state_d = S_DIV;
			end
			S_NY: begin
				cmd.op  = OP_NY;
				state_d = S_D1;
			end
			S_D1: begin
				cmd.mul = MS_VXNX;
				state_d = S_D2;
			end
			S_D2: begin
				cmd.op  = OP_DOT0;
				cmd.mul = MS_VYNY;
				state_d = S_D3;
			end
			S_D3: begin
				cmd.op  = OP_DOT1;
				cmd.mul = MS_VXNY;
				state_d = S_D4;
			end
			S_D4: begin
				cmd.op  = OP_CRS0;
				cmd.mul = MS_VYNX;
				state_d = S_D5;
			end
			S_D5: begin
				cmd.op  = OP_CRS1;
				state_d = S_FLIP;
			end
			S_FLIP: begin
				cmd.op  = OP_FLIP;
				state_d = S_ANORM;
			end
			S_ANORM: begin
				// A viewpoint on the query point skips the CORDIC entirely.
				if (stat.ang_zero) begin
					state_d = S_OUT_OK;
				end else if (stat.anorm_ok) begin
					cmd.op  = OP_CINIT;
					state_d = S_CORD;
				end else begin
					cmd.op = OP_ANORM;
				end
			end
			S_CORD: begin
				cmd.op = OP_CSTEP;
				if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = S_OUT_OK;
			end
			S_OUT_OK: begin
				cmd.res = OUT_VALID;
				state_d = S_IDLE;
			end
			S_OUT_FEW: begin
				cmd.res = OUT_FEW;
				state_d = S_IDLE;
			end
			S_OUT_ZERO: begin
				cmd.res = OUT_ZERO;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The step counter runs while a state repeats and restarts on any change.
	assign cnt_d = (state_d == state_q) ? cnt_q + 5'd1 : 5'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 5'd0;
			pass_q  <= 1'b0;
			divy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pass_q  <= pass_d;
			divy_q  <= divy_d;
		end
	end

endmodule

/* hw/rtl/pne2d_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pne2d_dp
// Datapath: group accumulators, a shared registered multiplier, a bit-serial
// square root, a restoring divider and a CORDIC vectoring unit.
// ----------------------------------------------------------------------------
module pne2d_dp import pne2d_pkg::*; #(
	parameter int MAX_NEIGHBORS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	input  cmd_t        cmd,
	output stat_t       stat,
	output result_t     result,
	output logic        result_valid
);

	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Group state and configuration
	logic signed [23:0] view_x_q, view_y_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [23:0] first_x_q, first_y_q;
	logic signed [24:0] second_dx_q, second_dy_q;
	logic signed [31:0] sum_dx_q, sum_dy_q;
	logic signed [56:0] sum_dxx_q, sum_dyy_q;
	logic signed [57:0] sum_dxy_q;
	logic               overflowed_q;
	result_t            result_q;
	logic               result_valid_q;

	// Working registers
	item_t              item_q;
	logic signed [24:0] dx_q, dy_q;
	logic signed [63:0] p_q, sxx_q, syy_q, sxy_q;
	logic [63:0]        wa_q, wb_q, sq_q, rt_q, bit_q;
	logic               d_neg_q, sxy_neg_q;
	logic signed [31:0] vx_q, vy_q;
	logic [14:0]        quo_q;
	logic signed [15:0] nx_q, ny_q;
	logic signed [41:0] dot_q, crs_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [23:0] z_q;

	// Shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic signed [24:0] vpx, vpy;

	assign vpx = 25'(view_x_q) - 25'(item_q.query_x);
	assign vpy = 25'(view_y_q) - 25'(item_q.query_y);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul)
			MS_DXDX: begin ma = 33'(dx_q);     mb = 33'(dx_q);     end
			MS_DYDY: begin ma = 33'(dy_q);     mb = 33'(dy_q);     end
			MS_DXDY: begin ma = 33'(dx_q);     mb = 33'(dy_q);     end
			MS_SXSX: begin ma = 33'(sum_dx_q); mb = 33'(sum_dx_q); end
			MS_SYSY: begin ma = 33'(sum_dy_q); mb = 33'(sum_dy_q); end
			MS_SXSY: begin ma = 33'(sum_dx_q); mb = 33'(sum_dy_q); end
			MS_AA: begin
				ma = $signed({1'b0, wa_q[31:0]});
				mb = $signed({1'b0, wa_q[31:0]});
			end
			MS_BB: begin
				ma = $signed({1'b0, wb_q[31:0]});
				mb = $signed({1'b0, wb_q[31:0]});
			end
			MS_VXNX: begin ma = 33'(vpx); mb = 33'(nx_q); end
			MS_VYNY: begin ma = 33'(vpy); mb = 33'(ny_q); end
			MS_VXNY: begin ma = 33'(vpx); mb = 33'(ny_q); end
			MS_VYNX: begin ma = 33'(vpy); mb = 33'(nx_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign mp = ma * mb;

	// Narrow count by wide sum product for the scatter terms
	logic signed [57:0]        nsel;
	logic signed [58+CNT_W:0]  nfull;
	logic signed [63:0]        nprod;

	always_comb begin
		case (cmd.op)
			OP_COV_XX: nsel = 58'(sum_dxx_q);
			OP_COV_YY: nsel = 58'(sum_dyy_q);
			default:   nsel = sum_dxy_q;
		endcase
	end

	assign nfull = nsel * $signed({1'b0, count_q});
	assign nprod = 64'(nfull);

	// Status
	logic        count_lt_max;
	logic [63:0] wmax;
	logic signed [63:0] dval;
	logic [63:0] sxy_mag;

	assign count_lt_max = (count_q < CNT_W'(MAX_NEIGHBORS));
	assign wmax         = (wa_q > wb_q) ? wa_q : wb_q;
	assign dval         = sxx_q - syy_q;
	assign sxy_mag      = mag64(sxy_q);

	always_comb begin
		stat.has_point = !item_q.no_point && count_lt_max;
		stat.is_last   = item_q.last;
		stat.few       = (count_q < CNT_W'(2));
		stat.two       = (count_q == CNT_W'(2));
		stat.big28     = (wa_q[63:28] != '0) || (wb_q[63:28] != '0);
		stat.unorm_ok  = (wmax[63:29] == '0) && wmax[28];
		stat.anorm_ok  = (wmax[63:30] == '0) && wmax[29];
		stat.vec_zero  = (vx_q == '0) && (vy_q == '0);
		stat.ang_zero  = (wa_q == '0) && (wb_q == '0);
	end

	// Axis candidate from the root of the discriminant
	logic signed [31:0] tval, sval;
	assign tval = sxy_neg_q ? $signed(32'(wb_q[27:0])) : -$signed(32'(wb_q[27:0]));
	assign sval = $signed(rt_q[31:0] + 32'(wa_q[27:0]));

	logic [63:0] sq_try;
	assign sq_try = rt_q + bit_q;

	logic signed [33:0] csx, csy;
	assign csx = cx_q >>> cmd.step;
	assign csy = cy_q >>> cmd.step;

	// Angle rounding
	logic [22:0] zpos;
	logic [15:0] zq;
	assign zpos = z_q[23] ? 23'd0 : z_q[22:0];
	assign zq   = 16'((zpos + 23'd64) >> 7);

	logic [31:0] vx_abs, vy_abs;
	assign vx_abs = vx_q[31] ? 32'(-vx_q) : 32'(vx_q);
	assign vy_abs = vy_q[31] ? 32'(-vy_q) : 32'(vy_q);

	logic out_any;
	assign out_any = (cmd.res != OUT_NONE);

	// Registers with a reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q       <= '0;
			view_y_q       <= '0;
			count_q        <= '0;
			first_x_q      <= '0;
			first_y_q      <= '0;
			second_dx_q    <= '0;
			second_dy_q    <= '0;
			sum_dx_q       <= '0;
			sum_dy_q       <= '0;
			sum_dxx_q      <= '0;
			sum_dyy_q      <= '0;
			sum_dxy_q      <= '0;
			overflowed_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= out_any;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VIEW_X: view_x_q <= cfg_data;
					REG_VIEW_Y: view_y_q <= cfg_data;
					default:    ;
				endcase
			end
			case (cmd.op)
				OP_DIFF: begin
					if (!item_q.no_point && !count_lt_max) overflowed_q <= 1'b1;
					if (stat.has_point && count_q == '0) begin
						first_x_q <= item_q.pt_x;
						first_y_q <= item_q.pt_y;
					end
				end
				OP_ACC_X: begin
					sum_dxx_q <= sum_dxx_q + 57'(p_q);
					sum_dx_q  <= sum_dx_q + 32'(dx_q);
					sum_dy_q  <= sum_dy_q + 32'(dy_q);
					if (count_q == CNT_W'(1)) begin
						second_dx_q <= dx_q;
						second_dy_q <= dy_q;
					end
				end
				OP_ACC_Y:  sum_dyy_q <= sum_dyy_q + 57'(p_q);
				OP_ACC_XY: begin
					sum_dxy_q <= sum_dxy_q + 58'(p_q);
					count_q   <= count_q + CNT_W'(1);
				end
				default: ;
			endcase
			// Every result closes the group.
			if (out_any) begin
				count_q      <= '0;
				first_x_q    <= '0;
				first_y_q    <= '0;
				second_dx_q  <= '0;
				second_dy_q  <= '0;
				sum_dx_q     <= '0;
				sum_dy_q     <= '0;
				sum_dxx_q    <= '0;
				sum_dyy_q    <= '0;
				sum_dxy_q    <= '0;
				overflowed_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		p_q <= 64'(mp);
		case (cmd.res)
			OUT_FEW: begin
				result_q <= '{norm_x: '0, norm_y: '0, view_angle: '0, status: ST_FEW};
			end
			OUT_ZERO: begin
				result_q <= '{norm_x: '0, norm_y: '0, view_angle: '0, status: ST_ZERO};
			end
			OUT_VALID: begin
				result_q.norm_x <= nx_q;
				result_q.norm_y <= ny_q;
				if (stat.ang_zero || zq > 16'(HALF_PI_Q13)) result_q.view_angle <= HALF_PI_Q13;
				else result_q.view_angle <= zq[13:0];
				result_q.status <= overflowed_q ? ST_DROP : ST_OK;
			end
			default: ;
		endcase
		case (cmd.op) inside
			OP_LOAD: item_q <= item;
			OP_DIFF: begin
				if (count_q == '0) begin
					dx_q <= '0;
					dy_q <= '0;
				end else begin
					dx_q <= 25'(item_q.pt_x) - 25'(first_x_q);
					dy_q <= 25'(item_q.pt_y) - 25'(first_y_q);
				end
			end
			OP_COV_XX: sxx_q <= nprod - p_q;
			OP_COV_YY: syy_q <= nprod - p_q;
			OP_COV_XY: sxy_q <= nprod - p_q;
			OP_DE: begin
				wa_q      <= mag64(dval);
				wb_q      <= {sxy_mag[62:0], 1'b0};
				d_neg_q   <= dval[63];
				sxy_neg_q <= sxy_q[63];
			end
			OP_SHR: begin
				wa_q <= wa_q >> 1;
				wb_q <= wb_q >> 1;
			end
			OP_SQ0: sq_q <= p_q;
			OP_SQ1: begin
				sq_q  <= sq_q + p_q;
				rt_q  <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT: begin
				if (sq_q >= sq_try) begin
					sq_q <= sq_q - sq_try;
					rt_q <= (rt_q >> 1) + bit_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_AXIS: begin
				if (!d_neg_q) begin
					vx_q <= tval;
					vy_q <= sval;
				end else begin
					vx_q <= sval;
					vy_q <= tval;
				end
			end
			OP_CANON: begin
				if (vx_q[31] || (vx_q == '0 && vy_q[31])) begin
					vx_q <= -vx_q;
					vy_q <= -vy_q;
				end
			end
			OP_TWO: begin
				vx_q <= 32'(second_dy_q);
				vy_q <= -32'(second_dx_q);
			end
			OP_UMAG: begin
				wa_q <= {32'd0, vx_abs};
				wb_q <= {32'd0, vy_abs};
			end
			OP_UNORM, OP_ANORM: begin
				// Scale both magnitudes until the larger one sits in the target octave.
				if ((cmd.op == OP_UNORM) ? (wmax[63:29] != '0) : (wmax[63:30] != '0)) begin
					wa_q <= wa_q >> 1;
					wb_q <= wb_q >> 1;
				end else if ((cmd.op == OP_UNORM) ? !wmax[28] : !wmax[29]) begin
					wa_q <= wa_q << 1;
					wb_q <= wb_q << 1;
				end
			end
			OP_DIVX_INIT: begin
				sq_q  <= (wa_q << 15) + rt_q;
				bit_q <= rt_q << 15;
				quo_q <= '0;
			end
			OP_DIVY_INIT: begin
				sq_q  <= (wb_q << 15) + rt_q;
				bit_q <= rt_q << 15;
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				if (sq_q >= bit_q) begin
					sq_q  <= sq_q - bit_q;
					quo_q <= {quo_q[13:0], 1'b1};
				end else begin
					quo_q <= {quo_q[13:0], 1'b0};
				end
				bit_q <= bit_q >> 1;
			end
			OP_NX: nx_q <= vx_q[31] ? -$signed(16'(quo_q)) : $signed(16'(quo_q));
			OP_NY: ny_q <= vy_q[31] ? -$signed(16'(quo_q)) : $signed(16'(quo_q));
			OP_DOT0: dot_q <= 42'(p_q);
			OP_DOT1: dot_q <= dot_q + 42'(p_q);
			OP_CRS0: crs_q <= 42'(p_q);
			OP_CRS1: crs_q <= crs_q - 42'(p_q);
			OP_FLIP: begin
				if (dot_q[41]) begin
					nx_q <= -nx_q;
					ny_q <= -ny_q;
				end
				wa_q <= mag64(64'(dot_q));
				wb_q <= mag64(64'(crs_q));
			end
			OP_CINIT: begin
				cx_q <= $signed(34'(wa_q[29:0]));
				cy_q <= $signed(34'(wb_q[29:0]));
				z_q  <= '0;
			end
			OP_CSTEP: begin
				if (!cy_q[33]) begin
					cx_q <= cx_q + csy;
					cy_q <= cy_q - csx;
					z_q  <= z_q + $signed(24'(atan_q20(cmd.step)));
				end else begin
					cx_q <= cx_q - csy;
					cy_q <= cy_q + csx;
					z_q  <= z_q - $signed(24'(atan_q20(cmd.step)));
				end
			end
			default: ;
		endcase
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

/* hw/rtl/pca_normal_2d_estimator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_normal_2d_estimator_top
// 2D PCA normal estimator: one neighbor point per transaction, one normal,
// view angle and status per group.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A point item
// keeps busy high while one shared multiplier forms dx*dx, dy*dy and dx*dy
// in turn; an item with no point or a dropped point skips these products.
// The item marked last then runs the group computation: the 32-step square
// root (twice for three or more points, once for a pair), the 15-step
// divider (twice), the 21-step CORDIC (skipped when the viewpoint is on the
// query point), and magnitude scaling loops. Groups of fewer than two points
// go straight to their status result after accumulation. The result appears
// for exactly one cycle with result_valid and cannot be held off; the
// receiver must take it then. Configuration writes are taken at any clock
// edge with cfg_we high and should be made only while idle.
module pca_normal_2d_estimator_top import pne2d_pkg::*; #(
	parameter int MAX_NEIGHBORS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        result_valid,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	pne2d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pne2d_dp #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

/* tb/tb_pca_normal_2d_estimator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pca_normal_2d_estimator_top
// Self-checking testbench for the 2D PCA normal estimator. Neighbor groups
// are sent one point per transaction, and an internal bit-exact predictor of
// the accumulation, eigenvector, unit scaling, view flip and angle steps
// supplies the expected normal, angle and status for every closed group.
// ----------------------------------------------------------------------------
module tb_pca_normal_2d_estimator_top;
	import pne2d_pkg::*;

	localparam int MAX_PTS    = 64;
	localparam int DRAIN_WAIT = 400;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        result_valid;
	result_t     result;
	logic        cfg_we;
	logic        cfg_index;
	logic [23:0] cfg_data;

	pca_normal_2d_estimator_top #(.MAX_NEIGHBORS(MAX_PTS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_valid(result_valid), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: viewpoint and the running group sums.
	longint view_xp, view_yp;
	int     pt_count;
	longint org_x, org_y, sec_dx, sec_dy;
	longint acc_dx, acc_dy, acc_dxx, acc_dyy, acc_dxy;
	bit     dropped;

	result_t expected_normals[$];
	int      errors;
	bit      no_gaps;

	localparam longint ATAN_TBL[21] = '{823550, 486170, 256879, 130396, 65451, 32757,
		16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("tb_pca_normal_2d_estimator_top failed");
		$finish;
	end

	function automatic longint unsigned absval(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic void unit_scale(longint vx, longint vy, output longint nx,
		output longint ny);
		longint unsigned ux, uy, m, len, qx, qy;
		ux = absval(vx);
		uy = absval(vy);
		m = (ux > uy) ? ux : uy;
		while (m < (64'd1 << 28)) begin ux <<= 1; uy <<= 1; m <<= 1; end
		while (m >= (64'd1 << 29)) begin ux >>= 1; uy >>= 1; m >>= 1; end
		len = floor_sqrt(ux * ux + uy * uy);
		qx = (ux * 32768 + len) / (2 * len);
		qy = (uy * 32768 + len) / (2 * len);
		nx = (vx < 0) ? -longint'(qx) : longint'(qx);
		ny = (vy < 0) ? -longint'(qy) : longint'(qy);
	endfunction

	function automatic logic [13:0] view_angle_of(longint unsigned x, longint unsigned y);
		longint unsigned m, q;
		longint cx, cy, z, shy, shx;
		z = 0;
		m = (x > y) ? x : y;
		if (m == 0) return HALF_PI_Q13;
		while (m < (64'd1 << 29)) begin x <<= 1; y <<= 1; m <<= 1; end
		while (m >= (64'd1 << 30)) begin x >>= 1; y >>= 1; m >>= 1; end
		cx = x;
		cy = y;
		for (int i = 0; i < 21; i++) begin
			shy = cy >>> i;
			shx = cx >>> i;
			if (cy >= 0) begin
				cx += shy; cy -= shx; z += ATAN_TBL[i];
			end else begin
				cx -= shy; cy += shx; z -= ATAN_TBL[i];
			end
		end
		if (z < 0) z = 0;
		q = (longint'(z) + 64) >> 7;
		return (q > HALF_PI_Q13) ? HALF_PI_Q13 : q[13:0];
	endfunction

	task automatic clear_group();
		pt_count = 0;
		org_x = 0; org_y = 0; sec_dx = 0; sec_dy = 0;
		acc_dx = 0; acc_dy = 0; acc_dxx = 0; acc_dyy = 0; acc_dxy = 0;
		dropped = 0;
	endtask

	// Advances the group model by one accepted item; queues a result on last.
	task automatic predict_normal(item_t it);
		longint px, py, dx, dy, vx, vy, n, cxx, cyy, cxy, d, t, nx, ny;
		longint vpx, vpy, dotp, crs;
		longint unsigned md, mb, r;
		result_t res;
		px = it.pt_x; py = it.pt_y;
		nx = 0; ny = 0;
		res = '0;
		if (!it.no_point) begin
			if (pt_count >= MAX_PTS) begin
				dropped = 1;
			end else begin
				if (pt_count == 0) begin org_x = px; org_y = py; end
				dx = px - org_x;
				dy = py - org_y;
				if (pt_count == 1) begin sec_dx = dx; sec_dy = dy; end
				acc_dx += dx; acc_dy += dy;
				acc_dxx += dx * dx; acc_dyy += dy * dy; acc_dxy += dx * dy;
				pt_count++;
			end
		end
		if (!it.last) return;
		if (pt_count < 2) begin
			res.status = ST_FEW;
		end else begin
			if (pt_count == 2) begin
				vx = sec_dy;
				vy = -sec_dx;
			end else begin
				n = pt_count;
				cxx = n * acc_dxx - acc_dx * acc_dx;
				cyy = n * acc_dyy - acc_dy * acc_dy;
				cxy = n * acc_dxy - acc_dx * acc_dy;
				d = cxx - cyy;
				md = absval(d);
				mb = 2 * absval(cxy);
				while (md >= (64'd1 << 28) || mb >= (64'd1 << 28)) begin
					md >>= 1; mb >>= 1;
				end
				r = floor_sqrt(md * md + mb * mb);
				t = (cxy < 0) ? longint'(mb) : -longint'(mb);
				if (d >= 0) begin vx = t; vy = r + md; end
				else begin vx = r + md; vy = t; end
				if (vx < 0 || (vx == 0 && vy < 0)) begin vx = -vx; vy = -vy; end
			end
			if (vx == 0 && vy == 0) begin
				res.status = ST_ZERO;
			end else begin
				vpx = view_xp - longint'(it.query_x);
				vpy = view_yp - longint'(it.query_y);
				unit_scale(vx, vy, nx, ny);
				dotp = vpx * nx + vpy * ny;
				crs = vpx * ny - vpy * nx;
				if (dotp < 0) begin nx = -nx; ny = -ny; end
				res.norm_x = nx[15:0];
				res.norm_y = ny[15:0];
				res.view_angle = view_angle_of(absval(dotp), absval(crs));
				res.status = dropped ? ST_DROP : ST_OK;
			end
		end
		expected_normals.push_back(res);
		clear_group();
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_normals.size() == 0) begin
				errors++;
				$display("%0t: unexpected result nx=%0d ny=%0d ang=%0d st=%0d", $time,
					result.norm_x, result.norm_y, result.view_angle, result.status);
			end else begin
				result_t e;
				e = expected_normals.pop_front();
				if (result.norm_x !== e.norm_x || result.norm_y !== e.norm_y ||
					result.view_angle !== e.view_angle || result.status !== e.status) begin
					errors++;
					$display("%0t: mismatch expected nx=%0d ny=%0d ang=%0d st=%0d, actual nx=%0d ny=%0d ang=%0d st=%0d",
						$time, e.norm_x, e.norm_y, e.view_angle, e.status,
						result.norm_x, result.norm_y, result.view_angle, result.status);
				end
			end
		end
	end

	// Sends one transaction after a random gap; start stays high across gapless items.
	task automatic send_item(item_t it);
		int gap;
		if (no_gaps) gap = 0;
		else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
		else gap = $urandom_range(0, 2);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_normal(it);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_normals.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_view(logic idx, logic [23:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_VIEW_X) view_xp = longint'(signed'(val));
		else view_yp = longint'(signed'(val));
	endtask

	function automatic item_t mk_pt(logic [23:0] x, logic [23:0] y, bit lst,
		logic [23:0] qx = 24'd0, logic [23:0] qy = 24'd0, bit nop = 0);
		item_t it;
		it.pt_x = x; it.pt_y = y; it.query_x = qx; it.query_y = qy;
		it.no_point = nop; it.last = lst;
		return it;
	endfunction

	function automatic logic [23:0] rand_coord(logic [23:0] base, int mode);
		if (mode == 0) return 24'($urandom);
		return base + 24'(signed'($urandom_range(0, 2 * mode) - mode));
	endfunction

	// Random group: mostly clustered around a random base, some full-range; some items carry no point.
	task automatic send_random_group(int size);
		logic [23:0] bx, by;
		int mode;
		item_t it;
		bx = 24'($urandom);
		by = 24'($urandom);
		case ($urandom_range(0, 3))
			0:       mode = 0;
			1:       mode = 16;
			2:       mode = 4096;
			default: mode = 200000;
		endcase
		for (int k = 0; k < size; k++) begin
			it = mk_pt(rand_coord(bx, mode), rand_coord(by, mode), k == size - 1,
				24'($urandom), 24'($urandom), $urandom_range(0, 15) == 0);
			if ($urandom_range(0, 7) == 0) begin
				it.query_x = it.pt_x;
				it.query_y = it.pt_y;
			end
			send_item(it);
		end
	endtask

	task automatic test_directed();
		// Empty group, single point, and a no-point closing item.
		send_item(mk_pt(24'h7FFFFF, 24'h800000, 1, 24'h7FFFFF, 24'h800000, 1));
		send_item(mk_pt(24'h7FFFFF, 24'h7FFFFF, 1));
		send_item(mk_pt(24'h800000, 24'h800000, 0));
		send_item(mk_pt(24'h7FFFFF, 24'h7FFFFF, 0));
		send_item(mk_pt(24'h0, 24'h0, 1, 24'h123456, 24'hFEDCBA, 1));
		// Coincident pair gives a zero-length direction.
		send_item(mk_pt(24'h001000, 24'h002000, 0));
		send_item(mk_pt(24'h001000, 24'h002000, 1, 24'h7FFFFF, 24'h800000));
		// Square corners: equal spreads and no cross term.
		send_item(mk_pt(24'h0, 24'h0, 0));
		send_item(mk_pt(24'h001000, 24'h0, 0));
		send_item(mk_pt(24'h0, 24'h001000, 0));
		send_item(mk_pt(24'h001000, 24'h001000, 1));
		// Collinear triple with the viewpoint on the query point.
		send_item(mk_pt(24'h0, 24'h0, 0));
		send_item(mk_pt(24'h001000, 24'h000800, 0));
		send_item(mk_pt(24'h002000, 24'h001000, 1, 24'h0, 24'h0));
		// Extreme spread in three points.
		send_item(mk_pt(24'h800000, 24'h7FFFFF, 0));
		send_item(mk_pt(24'h7FFFFF, 24'h800000, 0));
		send_item(mk_pt(24'h000001, 24'h000003, 1, 24'h800000, 24'h7FFFFF));
		// Vertical pair.
		send_item(mk_pt(24'h000100, 24'h0, 0));
		send_item(mk_pt(24'h000100, 24'h7FFFFF, 1, 24'h400000, 24'hC00000));
	endtask

	task automatic test_overflow();
		send_random_group(MAX_PTS + 6);
		// Coincident points past the limit still report a zero direction, not a drop.
		for (int k = 0; k < MAX_PTS + 2; k++)
			send_item(mk_pt(24'h000500, 24'hFFF000, k == MAX_PTS + 1));
		for (int k = 0; k < MAX_PTS; k++)
			send_item(mk_pt(24'($urandom), 24'($urandom), k == MAX_PTS - 1,
				24'($urandom), 24'($urandom)));
	endtask

	task automatic test_random(int n_items);
		int sent, sz;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 40) == 0) sz = $urandom_range(60, 68);
			else sz = $urandom_range(1, 7);
			no_gaps = ($urandom_range(0, 4) == 0);
			send_random_group(sz);
			sent += sz;
			if ($urandom_range(0, 30) == 0) drain();
		end
		no_gaps = 0;
	endtask

	task automatic test_viewpoints();
		write_view(REG_VIEW_X, 24'h7FFFFF);
		write_view(REG_VIEW_Y, 24'h800000);
		test_random(150);
		write_view(REG_VIEW_X, 24'h800000);
		write_view(REG_VIEW_Y, 24'h7FFFFF);
		test_random(150);
		write_view(REG_VIEW_X, 24'($urandom));
		write_view(REG_VIEW_Y, 24'($urandom));
		test_random(200);
	endtask

	initial begin
		clk = 1'b0;
		errors = 0;
		no_gaps = 0;
		view_xp = 0;
		view_yp = 0;
		clear_group();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_VIEW_X;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random(100);
		test_viewpoints();
		drain();
		if (errors == 0 && expected_normals.size() == 0) begin
			$display("tb_pca_normal_2d_estimator_top passed");
		end else begin
			$display("tb_pca_normal_2d_estimator_top failed");
		end
		$finish;
	end

endmodule
